>>> hdl/rmmv_pkg.sv
// Shared types, constants and command codes for the running summary block.
package rmmv_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF  = 32;

    // Datapath widths
    localparam int MEAN_W = 48;              // signed Q32.16 mean
    localparam int MAG_W  = 49;              // magnitude of a mean difference
    localparam int PROD_W = 2 * MAG_W + 64;  // d*d*n1*n2
    localparam int NUM_W  = PROD_W - 32;     // dividend after dropping 32 fraction bits
    localparam int M2_W   = 63;
    localparam int STEP_W = $clog2(NUM_W);

    localparam logic [M2_W-1:0] M2_LIMIT = '1;

    // Request codes
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_MERGE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Datapath command codes
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_ACCEPT    = 4'd1;
    localparam logic [3:0] OP_MUL_STEP  = 4'd2;
    localparam logic [3:0] OP_DIV_STEP  = 4'd3;
    localparam logic [3:0] OP_PUSH_MEAN = 4'd4;
    localparam logic [3:0] OP_PUSH_M2   = 4'd5;
    localparam logic [3:0] OP_MRG_DIV1  = 4'd6;
    localparam logic [3:0] OP_MRG_MEAN  = 4'd7;
    localparam logic [3:0] OP_MRG_MUL2  = 4'd8;
    localparam logic [3:0] OP_MRG_MUL3  = 4'd9;
    localparam logic [3:0] OP_MRG_DIV2  = 4'd10;
    localparam logic [3:0] OP_MRG_M2    = 4'd11;
    localparam logic [3:0] OP_LOAD_RES  = 4'd12;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] sample;
        logic [31:0]        part_count;
        logic signed [31:0] part_min;
        logic signed [31:0] part_max;
        logic signed [31:0] part_mean;
        logic [62:0]        part_m2;
    } req_t;

    typedef struct packed {
        logic [31:0]        count_out;
        logic signed [31:0] min_out;
        logic signed [31:0] max_out;
        logic signed [31:0] mean_out;
        logic [62:0]        m2_out;
        logic               saturated;
    } res_t;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       empty;
        logic       res_busy;
    } sts_t;

endpackage

>>> hdl/rmmv_ctrl.sv
// Sequencer that steps the datapath through push, merge and clear transactions.
module rmmv_ctrl
    import rmmv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MAG_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(NUM_W - 1);

    logic [2:0]        state_reg, state_next;
    logic [3:0]        phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // Decide the next state and the command for this cycle
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op = OP_ACCEPT;
                    case (sts.kind)
                        REQ_PUSH:
                        begin
                            state_next = S_DIV;
                            step_next  = DIV_LAST;
                            phase_next = OP_PUSH_MEAN;
                        end
                        REQ_MERGE:
                        begin
                            if (sts.empty)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MUL;
                                step_next  = MUL_LAST;
                                phase_next = OP_MRG_DIV1;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.op = OP_MUL_STEP;
                if (step_reg == '0)
                    state_next = S_SETUP;
                else
                    step_next = step_reg - 1'b1;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (step_reg == '0)
                    state_next = S_SETUP;
                else
                    step_next = step_reg - 1'b1;
            end
            S_SETUP:
            begin
                cmd.op = phase_reg;
                case (phase_reg)
                    OP_PUSH_MEAN:
                    begin
                        state_next = S_MUL;
                        step_next  = MUL_LAST;
                        phase_next = OP_PUSH_M2;
                    end
                    OP_MRG_DIV1:
                    begin
                        state_next = S_DIV;
                        step_next  = DIV_LAST;
                        phase_next = OP_MRG_MEAN;
                    end
                    OP_MRG_MEAN:
                    begin
                        state_next = S_MUL;
                        step_next  = MUL_LAST;
                        phase_next = OP_MRG_MUL2;
                    end
                    OP_MRG_MUL2:
                    begin
                        state_next = S_MUL;
                        step_next  = MUL_LAST;
                        phase_next = OP_MRG_MUL3;
                    end
                    OP_MRG_MUL3:
                    begin
                        state_next = S_MUL;
                        step_next  = MUL_LAST;
                        phase_next = OP_MRG_DIV2;
                    end
                    OP_MRG_DIV2:
                    begin
                        state_next = S_DIV;
                        step_next  = DIV_LAST;
                        phase_next = OP_MRG_M2;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DONE:
            begin
                if (!sts.res_busy)
                begin
                    cmd.op     = OP_LOAD_RES;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

    // Advance the state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= OP_NONE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid) |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start");

    a_mul_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (step_reg <= MUL_LAST))
        else $error("multiply step count out of range");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !sts.res_busy) |=> (state_reg == S_IDLE))
        else $error("result load did not return to idle");

endmodule

>>> hdl/rmmv_dp.sv
// Datapath: summary registers, bit-serial multiplier, restoring divider, result register.
module rmmv_dp
    import rmmv_pkg::*;
#(
    parameter int SW = SAMPLE_WIDTH_DEF,
    parameter int CW = COUNT_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    output sts_t sts,
    input  req_t req_item,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_item
);

    localparam int NW = CW + 1;
    localparam logic signed [31:0] SMAX = 32'(2 ** (SW - 1) - 1);
    localparam logic signed [31:0] SMIN = ~SMAX;
    localparam logic [CW-1:0] CNT_MAX = '1;

    // Summary state
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic signed [31:0]       min_reg, min_next;
    logic signed [31:0]       max_reg, max_next;
    logic signed [MEAN_W-1:0] mean_reg, mean_next;
    logic [M2_W-1:0]          m2_reg, m2_next;
    logic                     sat_reg, sat_next;

    // Work registers
    logic [MAG_W-1:0]         dmag_reg, dmag_next;
    logic                     dneg_reg, dneg_next;
    logic signed [MEAN_W-1:0] xs_reg, xs_next;
    logic [CW-1:0]            n1_reg, n1_next;
    logic [CW-1:0]            n2_reg, n2_next;
    logic [NW-1:0]            div_reg, div_next;
    logic [M2_W-1:0]          pm2_reg, pm2_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [PROD_W-1:0]        mcand_reg, mcand_next;
    logic [MAG_W-1:0]         mplier_reg, mplier_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [NW-1:0]            rem_reg, rem_next;
    logic [NUM_W-1:0]         quo_reg, quo_next;
    res_t                     res_reg, res_next;
    logic                     res_valid_reg, res_valid_next;

    // Input decode
    logic signed [31:0]       x32, pmin32, pmax32, pmean32, src32, lo32, hi32;
    logic signed [MEAN_W-1:0] src_s;
    logic [49:0]              delta;
    logic [MAG_W-1:0]         delta_mag;
    logic [CW-1:0]            n2_in;
    logic [NW-1:0]            n_push, n_mrg;
    logic                     is_merge;

    // Shared arithmetic
    logic [NW:0]              rem_s;
    logic                     rem_ge;
    logic [MAG_W-1:0]         q_mean;
    logic [49:0]              q_signed, mean_sum, e_diff;
    logic [MEAN_W-1:0]        mean_new;
    logic [MAG_W-1:0]         e_mag;
    logic [M2_W:0]            term_p, term_q, add_p, add_a, add_b;
    logic [48:0]              round_r;
    logic signed [32:0]       round_q;
    logic signed [31:0]       mean_clamped;

    function automatic logic [M2_W:0] sat_term(input logic [NUM_W-1:0] v);
        logic ovf;
        ovf = (v > NUM_W'(M2_LIMIT));
        return ovf ? {1'b1, M2_LIMIT} : {1'b0, v[M2_W-1:0]};
    endfunction

    function automatic logic [M2_W:0] m2_add(input logic [M2_W-1:0] a, input logic [M2_W-1:0] b);
        logic [M2_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[M2_W] ? {1'b1, M2_LIMIT} : s;
    endfunction

    // Decode the incoming transaction
    assign x32      = 32'(signed'(req_item.sample[SW-1:0]));
    assign pmin32   = 32'(signed'(req_item.part_min[SW-1:0]));
    assign pmax32   = 32'(signed'(req_item.part_max[SW-1:0]));
    assign pmean32  = 32'(signed'(req_item.part_mean[SW-1:0]));
    assign is_merge = (req_item.req_type == REQ_MERGE);
    assign src32    = is_merge ? pmean32 : x32;
    assign lo32     = is_merge ? pmin32 : x32;
    assign hi32     = is_merge ? pmax32 : x32;
    assign src_s    = {src32, 16'h0000};
    assign delta    = 50'(src_s) - 50'(mean_reg);
    assign delta_mag = delta[49] ? MAG_W'(-delta) : MAG_W'(delta);
    assign n2_in    = req_item.part_count[CW-1:0];
    assign n_push   = NW'(cnt_reg) + NW'(1);
    assign n_mrg    = NW'(cnt_reg) + NW'(n2_in);

    assign sts.kind     = req_item.req_type;
    assign sts.empty    = (n_mrg == '0);
    assign sts.res_busy = res_valid_reg && res_stall;

    // Divider step
    assign rem_s  = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge = (rem_s >= {1'b0, div_reg});

    // Mean update from the rounded quotient, and the post-update deviation
    assign q_mean   = quo_reg[MAG_W-1:0];
    assign q_signed = dneg_reg ? -50'(q_mean) : 50'(q_mean);
    assign mean_sum = 50'(mean_reg) + q_signed;
    assign mean_new = mean_sum[MEAN_W-1:0];
    assign e_diff   = 50'(xs_reg) - 50'(signed'(mean_new));
    assign e_mag    = e_diff[49] ? MAG_W'(-e_diff) : MAG_W'(e_diff);

    // Saturating M2 terms
    assign term_p = sat_term(prod_reg[PROD_W-1:32]);
    assign term_q = sat_term(quo_reg);
    assign add_p  = m2_add(m2_reg, term_p[M2_W-1:0]);
    assign add_a  = m2_add(m2_reg, pm2_reg);
    assign add_b  = m2_add(add_a[M2_W-1:0], term_q[M2_W-1:0]);

    // Round the mean from Q32.16 to an integer and clamp to the sample range
    assign round_r = 49'(mean_reg) + 49'(32768);
    assign round_q = round_r[48:16];
    assign mean_clamped = (round_q > 33'(SMAX)) ? SMAX :
                          (round_q < 33'(SMIN)) ? SMIN : round_q[31:0];

    // Next-state logic per command
    always_comb
    begin
        cnt_next       = cnt_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        mean_next      = mean_reg;
        m2_next        = m2_reg;
        sat_next       = sat_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        xs_next        = xs_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        div_next       = div_reg;
        pm2_next       = pm2_reg;
        prod_next      = prod_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        case (cmd.op)
            OP_ACCEPT:
            begin
                case (req_item.req_type)
                    REQ_PUSH:
                    begin
                        if (lo32 < min_reg) min_next = lo32;
                        if (hi32 > max_reg) max_next = hi32;
                        dmag_next = delta_mag;
                        dneg_next = delta[49];
                        xs_next   = src_s;
                        div_next  = n_push;
                        num_next  = NUM_W'(delta_mag) + NUM_W'(n_push >> 1);
                        rem_next  = '0;
                    end
                    REQ_MERGE:
                    begin
                        if (lo32 < min_reg) min_next = lo32;
                        if (hi32 > max_reg) max_next = hi32;
                        if (n_mrg[CW])
                        begin
                            cnt_next = CNT_MAX;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            cnt_next = n_mrg[CW-1:0];
                        end
                        if (n_mrg == '0)
                        begin
                            mean_next = '0;
                            m2_next   = '0;
                        end
                        dmag_next   = delta_mag;
                        dneg_next   = delta[49];
                        n1_next     = cnt_reg;
                        n2_next     = n2_in;
                        div_next    = n_mrg;
                        pm2_next    = req_item.part_m2;
                        prod_next   = '0;
                        mcand_next  = PROD_W'(delta_mag);
                        mplier_next = MAG_W'(n2_in);
                    end
                    REQ_CLEAR:
                    begin
                        cnt_next  = '0;
                        min_next  = SMAX;
                        max_next  = SMIN;
                        mean_next = '0;
                        m2_next   = '0;
                        sat_next  = 1'b0;
                    end
                    default:
                    begin
                        sat_next = sat_reg;
                    end
                endcase
            end
            OP_MUL_STEP:
            begin
                if (mplier_reg[0]) prod_next = prod_reg + mcand_reg;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
            end
            OP_DIV_STEP:
            begin
                rem_next = rem_ge ? NW'(rem_s - {1'b0, div_reg}) : NW'(rem_s);
                num_next = num_reg << 1;
                quo_next = {quo_reg[NUM_W-2:0], rem_ge};
            end
            OP_PUSH_MEAN:
            begin
                mean_next   = mean_new;
                prod_next   = '0;
                mcand_next  = PROD_W'(dmag_reg);
                mplier_next = (dneg_reg == e_diff[49]) ? e_mag : '0;
            end
            OP_PUSH_M2:
            begin
                m2_next = add_p[M2_W-1:0];
                if (term_p[M2_W] || add_p[M2_W]) sat_next = 1'b1;
                if (cnt_reg == CNT_MAX)
                    sat_next = 1'b1;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            OP_MRG_DIV1:
            begin
                num_next = prod_reg[NUM_W-1:0] + NUM_W'(div_reg >> 1);
                rem_next = '0;
            end
            OP_MRG_MEAN:
            begin
                mean_next   = mean_new;
                prod_next   = '0;
                mcand_next  = PROD_W'(dmag_reg);
                mplier_next = dmag_reg;
            end
            OP_MRG_MUL2:
            begin
                prod_next   = '0;
                mcand_next  = prod_reg;
                mplier_next = MAG_W'(n1_reg);
            end
            OP_MRG_MUL3:
            begin
                prod_next   = '0;
                mcand_next  = prod_reg;
                mplier_next = MAG_W'(n2_reg);
            end
            OP_MRG_DIV2:
            begin
                num_next = prod_reg[PROD_W-1:32];
                rem_next = '0;
            end
            OP_MRG_M2:
            begin
                m2_next = add_b[M2_W-1:0];
                if (add_a[M2_W] || term_q[M2_W] || add_b[M2_W]) sat_next = 1'b1;
            end
            OP_LOAD_RES:
            begin
                res_next.count_out = 32'(cnt_reg);
                res_next.min_out   = min_reg;
                res_next.max_out   = max_reg;
                res_next.mean_out  = mean_clamped;
                res_next.m2_out    = m2_reg;
                res_next.saturated = sat_reg;
                res_valid_next     = 1'b1;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Hold the summary and control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            min_reg       <= SMAX;
            max_reg       <= SMIN;
            mean_reg      <= '0;
            m2_reg        <= '0;
            sat_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            mean_reg      <= mean_next;
            m2_reg        <= m2_next;
            sat_reg       <= sat_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Advance the work registers
    always_ff @(posedge clk)
    begin
        dmag_reg   <= dmag_next;
        dneg_reg   <= dneg_next;
        xs_reg     <= xs_next;
        n1_reg     <= n1_next;
        n2_reg     <= n2_next;
        div_reg    <= div_next;
        pm2_reg    <= pm2_next;
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

endmodule

>>> hdl/running_min_max_mean_variance.sv
// Top level of the running count, min, max, mean and M2 summary block.
//
//  channel | direction | payload | handshake
//  --------+-----------+---------+--------------------------
//  req     | in        | req_t   | req_valid / req_stall
//  res     | out       | res_t   | res_valid / res_stall
//
// One transaction at a time; each runs as steps on the bit-serial multiplier and
// the restoring divider. Push: divide, mean update, multiply, M2 update. Merge:
// multiply, divide, mean, three multiplies, divide, M2; clear, empty merge: none.
// Reset restores the empty summary at once; no clearing pass.
// A result waits in the output register while res_stall is high; the next
// request is taken meanwhile and finishes only when that register frees up.
module running_min_max_mean_variance
    import rmmv_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_item,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_item
);

    cmd_t cmd;
    sts_t sts;

    // Sequence each transaction
    rmmv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold the summary and do the arithmetic
    rmmv_dp #(
        .SW (SAMPLE_WIDTH),
        .CW (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
